FILE: rtl/vgfc_pkg.sv
// ----------------------------------------------------------------------------
// vgfc_pkg - shared types and constants of the voxel face culler
// Opcodes, register indexes, face codes, controller states, the result record
// and the small helpers used to build a result from a stored voxel word.
// ----------------------------------------------------------------------------
package vgfc_pkg;

   // field widths fixed by the interface
   localparam int SIZE_W = 5;
   localparam int POS_W  = 4;
   localparam int FACE_N = 6;
   localparam int WORD_W = 7;    // bit 0 on, bits 1..6 covered flags

   localparam logic [SIZE_W-1:0] SIZE_RESET     = 5'd16;
   localparam logic [2:0]        FULL_ENCLOSURE = 3'd6;   // every face covered

   // request opcodes; every other code reads
   typedef logic [1:0] op_type;
   localparam op_type OP_SET = 2'd0;
   localparam op_type OP_CLR = 2'd1;

   // configuration register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_SIZE_X = 2'd0;
   localparam csr_index_type CSR_SIZE_Y = 2'd1;
   localparam csr_index_type CSR_SIZE_Z = 2'd2;

   // face codes, in exposed-mask bit order; FACE_END closes the scan
   typedef logic [2:0] face_type;
   localparam face_type FACE_NEG_X = 3'd0;
   localparam face_type FACE_POS_X = 3'd1;
   localparam face_type FACE_NEG_Y = 3'd2;
   localparam face_type FACE_POS_Y = 3'd3;
   localparam face_type FACE_NEG_Z = 3'd4;
   localparam face_type FACE_POS_Z = 3'd5;
   localparam face_type FACE_END   = 3'd6;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              occupied;
      logic              was_changed;
      logic [FACE_N-1:0] exposed_faces;
      logic [2:0]        neighbor_total;
      logic              visible;
      logic              out_of_range;
   } result_type;

   localparam result_type RESULT_OOR = '{
      occupied: 1'b0, was_changed: 1'b0, exposed_faces: '0,
      neighbor_total: 3'd0, visible: 1'b0, out_of_range: 1'b1
   };

   function automatic logic [2:0] popcount6(input logic [FACE_N-1:0] v);
      logic [2:0] n;
      n = 3'd0;
      for (int i = 0; i < FACE_N; i++) begin
         n = n + {2'b00, v[i]};
      end
      return n;
   endfunction

   // flag in a neighbor's word that faces the cell on side f
   function automatic word_type cover_bit(input face_type f);
      word_type m;
      m = '0;
      unique case (f)
         FACE_NEG_X: m = 7'b0000100;
         FACE_POS_X: m = 7'b0000010;
         FACE_NEG_Y: m = 7'b0010000;
         FACE_POS_Y: m = 7'b0001000;
         FACE_NEG_Z: m = 7'b1000000;
         FACE_POS_Z: m = 7'b0100000;
         default:    m = '0;
      endcase
      return m;
   endfunction

   function automatic result_type make_result(input word_type w, input logic changed);
      result_type r;
      logic [2:0] total;
      total            = popcount6(w[WORD_W-1:1]);
      r.occupied       = w[0];
      r.was_changed    = changed;
      r.exposed_faces  = ~w[WORD_W-1:1];
      r.neighbor_total = total;
      r.visible        = w[0] && (total < FULL_ENCLOSURE);
      r.out_of_range   = 1'b0;
      return r;
   endfunction

endpackage

FILE: rtl/vgfc_if.sv
// ----------------------------------------------------------------------------
// vgfc_if - channel interfaces of the voxel face culler
// Request, response and register-write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface vgfc_req_if;
   logic                      valid;
   logic                      ready;
   vgfc_pkg::op_type          op;
   logic [vgfc_pkg::POS_W-1:0] pos_x;
   logic [vgfc_pkg::POS_W-1:0] pos_y;
   logic [vgfc_pkg::POS_W-1:0] pos_z;

   modport source (output valid, op, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, op, pos_x, pos_y, pos_z, output ready);
endinterface

interface vgfc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        occupied;
   logic                        was_changed;
   logic [vgfc_pkg::FACE_N-1:0] exposed_faces;
   logic [2:0]                  neighbor_total;
   logic                        visible;
   logic                        out_of_range;

   modport source (output valid, occupied, was_changed, exposed_faces,
                   neighbor_total, visible, out_of_range, input ready);
   modport sink   (input valid, occupied, was_changed, exposed_faces,
                   neighbor_total, visible, out_of_range, output ready);
endinterface

interface vgfc_csr_if;
   logic                        valid;
   logic                        ready;
   vgfc_pkg::csr_index_type     index;
   logic [vgfc_pkg::SIZE_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/vgfc_voxel_ram.sv
// ----------------------------------------------------------------------------
// vgfc_voxel_ram - voxel word store
// Simple dual-port synchronous RAM: one write and one read port, read data
// registered, and read data holds when no read is issued.
// ----------------------------------------------------------------------------
module vgfc_voxel_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/voxel_grid_face_culler_top.sv
// ----------------------------------------------------------------------------
// voxel_grid_face_culler_top - occupancy grid with hidden-face tracking
// Keeps one 7-bit word per voxel (on bit plus six covered-face flags) in a
// single RAM and keeps neighbor flags current on every set or clear.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan : one request per voxel op (set, clear, read) at pos_x/y/z.
//   rsp_chan : exactly one response per request, in request order.
//   csr_chan : writes size_x/size_y/size_z (index 0..2); always ready. Write
//              only while no request is in flight.
// Sequence per request (one request in flight at a time):
//   out of range            : accept, hand off
//   read, or no-op set/clear: read voxel, evaluate, hand off
//   set/clear that changes  : read voxel, evaluate and write it back, then
//                             the voxel RAM's read-modify-write of the
//                             in-bounds neighbors, one neighbor read and one write-back per cycle, then hand off.
//   Response appears in the cycle after the hand-off cycle.
// Reset: extents go to 16 and the RAM is swept to zero, one word a cycle,
//   over all 2**(3*clog2(MAX_EDGE)) words (4096 at MAX_EDGE=16); req_chan.ready
//   stays low during the sweep.
// Stall: the response sits in an output register; the next request is still
//   accepted, and its own result waits in the hand-off state until the
//   output register frees up.
// ----------------------------------------------------------------------------
module voxel_grid_face_culler_top #(
   parameter int MAX_EDGE = 16
) (
   input  logic       clock,
   input  logic       reset,
   vgfc_req_if.sink   req_chan,
   vgfc_rsp_if.source rsp_chan,
   vgfc_csr_if.sink   csr_chan
);

   localparam int CW = $clog2(MAX_EDGE);            // coordinate bits
   localparam int EW = $clog2(MAX_EDGE + 1);        // extent bits
   localparam int KW = (EW > vgfc_pkg::SIZE_W) ? EW : vgfc_pkg::SIZE_W;
   localparam int AW = 3 * CW;                      // RAM address bits
   localparam logic [KW-1:0] EDGE_MAX = KW'(MAX_EDGE);

   // clamp a size register to 1..MAX_EDGE
   function automatic logic [KW-1:0] clamp_ext(input logic [vgfc_pkg::SIZE_W-1:0] v);
      logic [KW-1:0] e;
      e = KW'(v);
      if (e == '0) begin
         e = KW'(1);
      end else if (e > EDGE_MAX) begin
         e = EDGE_MAX;
      end
      return e;
   endfunction

   // address of the neighbor on side f
   function automatic logic [AW-1:0] nb_addr(input vgfc_pkg::face_type f,
                                             input logic [CW-1:0] x,
                                             input logic [CW-1:0] y,
                                             input logic [CW-1:0] z);
      logic [CW-1:0] nx;
      logic [CW-1:0] ny;
      logic [CW-1:0] nz;
      nx = x;
      ny = y;
      nz = z;
      unique case (f)
         vgfc_pkg::FACE_NEG_X: nx = x - CW'(1);
         vgfc_pkg::FACE_POS_X: nx = x + CW'(1);
         vgfc_pkg::FACE_NEG_Y: ny = y - CW'(1);
         vgfc_pkg::FACE_POS_Y: ny = y + CW'(1);
         vgfc_pkg::FACE_NEG_Z: nz = z - CW'(1);
         vgfc_pkg::FACE_POS_Z: nz = z + CW'(1);
         default: nx = x;
      endcase
      return {nx, ny, nz};
   endfunction

   // configuration registers
   logic [vgfc_pkg::SIZE_W-1:0] size_x_ff;
   logic [vgfc_pkg::SIZE_W-1:0] size_y_ff;
   logic [vgfc_pkg::SIZE_W-1:0] size_z_ff;

   // controller state
   vgfc_pkg::state_type state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   vgfc_pkg::face_type     face_ff, face_in;
   logic                   pend_ff, pend_in;
   vgfc_pkg::face_type     pend_face_ff, pend_face_in;
   logic                   rsp_valid_ff;

   // request payload and working result
   vgfc_pkg::op_type       op_ff;
   logic [CW-1:0]          px_ff, py_ff, pz_ff;
   logic [vgfc_pkg::FACE_N-1:0] nb_mask_ff, nb_mask_in;
   vgfc_pkg::result_type   res_ff, res_in;
   vgfc_pkg::result_type   rsp_ff;

   logic [KW-1:0] ext_x, ext_y, ext_z;
   logic [KW-1:0] pxk, pyk, pzk;
   logic          oor;
   logic          req_fire;
   logic          load_rsp;
   logic          want;
   logic          is_write;
   logic          have;
   logic          change;
   logic          scan_rd;
   logic [AW-1:0] cen_addr;
   vgfc_pkg::word_type new_word;

   // RAM port signals
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   vgfc_pkg::word_type ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   vgfc_pkg::word_type ram_rdata;

   vgfc_voxel_ram #(
      .ADDR_W (AW),
      .DATA_W (vgfc_pkg::WORD_W)
   ) u_vgfc_voxel_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // effective extents and range check of the incoming request
   assign ext_x = clamp_ext(size_x_ff);
   assign ext_y = clamp_ext(size_y_ff);
   assign ext_z = clamp_ext(size_z_ff);
   assign pxk   = KW'(req_chan.pos_x);
   assign pyk   = KW'(req_chan.pos_y);
   assign pzk   = KW'(req_chan.pos_z);
   assign oor   = (pxk >= ext_x) || (pyk >= ext_y) || (pzk >= ext_z);

   // in-bounds neighbors of the requested voxel
   always_comb begin
      nb_mask_in = '0;
      nb_mask_in[vgfc_pkg::FACE_NEG_X] = (pxk != '0);
      nb_mask_in[vgfc_pkg::FACE_POS_X] = ((pxk + KW'(1)) < ext_x);
      nb_mask_in[vgfc_pkg::FACE_NEG_Y] = (pyk != '0);
      nb_mask_in[vgfc_pkg::FACE_POS_Y] = ((pyk + KW'(1)) < ext_y);
      nb_mask_in[vgfc_pkg::FACE_NEG_Z] = (pzk != '0);
      nb_mask_in[vgfc_pkg::FACE_POS_Z] = ((pzk + KW'(1)) < ext_z);
   end

   assign req_chan.ready = (state_ff == vgfc_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign cen_addr = {px_ff, py_ff, pz_ff};
   assign want     = (op_ff == vgfc_pkg::OP_SET);
   assign is_write = (op_ff == vgfc_pkg::OP_SET) || (op_ff == vgfc_pkg::OP_CLR);
   assign have     = ram_rdata[0];
   assign change   = is_write && (want != have);
   assign new_word = change ? {ram_rdata[vgfc_pkg::WORD_W-1:1], want} : ram_rdata;

   // next neighbor to fetch during the scan
   always_comb begin
      scan_rd = 1'b0;
      if (face_ff != vgfc_pkg::FACE_END) begin
         scan_rd = nb_mask_ff[face_ff];
      end
   end

   // sequencer: next state, RAM accesses, result capture
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      face_in      = face_ff;
      pend_in      = pend_ff;
      pend_face_in = pend_face_ff;
      res_in       = res_ff;
      load_rsp     = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = cen_addr;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = cen_addr;
      unique case (state_ff)
         vgfc_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (&clr_ff) begin
               state_in = vgfc_pkg::ST_IDLE;
            end
         end
         vgfc_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (oor) begin
                  res_in   = vgfc_pkg::RESULT_OOR;
                  state_in = vgfc_pkg::ST_DONE;
               end else begin
                  state_in = vgfc_pkg::ST_READ;
               end
            end
         end
         vgfc_pkg::ST_READ: begin
            ram_re   = 1'b1;
            state_in = vgfc_pkg::ST_EVAL;
         end
         vgfc_pkg::ST_EVAL: begin
            res_in = vgfc_pkg::make_result(new_word, change);
            if (change) begin
               ram_we    = 1'b1;
               ram_wdata = new_word;
               face_in   = vgfc_pkg::FACE_NEG_X;
               pend_in   = 1'b0;
               state_in  = vgfc_pkg::ST_SCAN;
            end else begin
               state_in  = vgfc_pkg::ST_DONE;
            end
         end
         vgfc_pkg::ST_SCAN: begin
            // write back the neighbor fetched last cycle
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = nb_addr(pend_face_ff, px_ff, py_ff, pz_ff);
               ram_wdata = want ? (ram_rdata | vgfc_pkg::cover_bit(pend_face_ff))
                                : (ram_rdata & ~vgfc_pkg::cover_bit(pend_face_ff));
            end
            // fetch the next one
            ram_re       = scan_rd;
            ram_raddr    = nb_addr(face_ff, px_ff, py_ff, pz_ff);
            pend_in      = scan_rd;
            pend_face_in = face_ff;
            if (face_ff == vgfc_pkg::FACE_END) begin
               state_in = vgfc_pkg::ST_DONE;
            end else begin
               face_in  = face_ff + 3'd1;
            end
         end
         vgfc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = vgfc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vgfc_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vgfc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         face_ff      <= vgfc_pkg::FACE_NEG_X;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         size_x_ff    <= vgfc_pkg::SIZE_RESET;
         size_y_ff    <= vgfc_pkg::SIZE_RESET;
         size_z_ff    <= vgfc_pkg::SIZE_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         face_ff  <= face_in;
         pend_ff  <= pend_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               vgfc_pkg::CSR_SIZE_X: size_x_ff <= csr_chan.data;
               vgfc_pkg::CSR_SIZE_Y: size_y_ff <= csr_chan.data;
               vgfc_pkg::CSR_SIZE_Z: size_z_ff <= csr_chan.data;
               default: size_x_ff <= size_x_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_face_ff <= pend_face_in;
      res_ff       <= res_in;
      if (req_fire) begin
         op_ff      <= req_chan.op;
         px_ff      <= pxk[CW-1:0];
         py_ff      <= pyk[CW-1:0];
         pz_ff      <= pzk[CW-1:0];
         nb_mask_ff <= nb_mask_in;
      end
      if (load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   // response channel
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.occupied       = rsp_ff.occupied;
   assign rsp_chan.was_changed    = rsp_ff.was_changed;
   assign rsp_chan.exposed_faces  = rsp_ff.exposed_faces;
   assign rsp_chan.neighbor_total = rsp_ff.neighbor_total;
   assign rsp_chan.visible        = rsp_ff.visible;
   assign rsp_chan.out_of_range   = rsp_ff.out_of_range;

endmodule

FILE: rtl/vgfc_checker.sv
// ----------------------------------------------------------------------------
// vgfc_checker - port-level checks of the voxel face culler
// Watches the top level's channels; attached to it by the bind below.
// ----------------------------------------------------------------------------
module vgfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       occupied,
   input logic       was_changed,
   input logic [5:0] exposed_faces,
   input logic [2:0] neighbor_total,
   input logic       visible,
   input logic       out_of_range
);

   // the RAM sweep after reset holds off requests
   a_reset_blocks_req: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted right after reset");

   // a stalled response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(exposed_faces)
         && $stable(neighbor_total) && $stable(out_of_range) && $stable(occupied))
      else $error("stalled response changed");

   // an ignored request reports nothing else
   a_oor_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_of_range |-> !occupied && !was_changed
         && exposed_faces == 6'd0 && neighbor_total == 3'd0 && !visible)
      else $error("out-of-range response carries voxel data");

   // neighbor count agrees with the covered faces
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !out_of_range |->
         32'(neighbor_total) == $countones(~exposed_faces))
      else $error("neighbor count disagrees with exposed mask");

   // a visible voxel is on and not fully enclosed
   a_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && visible |-> occupied && neighbor_total != 3'd6)
      else $error("visible flag on a hidden or empty voxel");

endmodule

bind voxel_grid_face_culler_top vgfc_checker u_vgfc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .occupied       (rsp_chan.occupied),
   .was_changed    (rsp_chan.was_changed),
   .exposed_faces  (rsp_chan.exposed_faces),
   .neighbor_total (rsp_chan.neighbor_total),
   .visible        (rsp_chan.visible),
   .out_of_range   (rsp_chan.out_of_range)
);

FILE: bench/voxel_grid_face_culler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_grid_face_culler_checker - response predictor and scoreboard
// Watches the request, response and register-write channels. Keeps its own
// copy of the voxel grid and the extents, works out the report for every
// accepted request and compares each accepted response with the oldest one.
// ----------------------------------------------------------------------------
module voxel_grid_face_culler_checker #(
   parameter int MAX_EDGE = 16
) (
   input  logic clock,
   input  logic reset,
   vgfc_req_if  req_mon,
   vgfc_rsp_if  rsp_mon,
   vgfc_csr_if  csr_mon,
   output int   fail_total,
   output int   pending_total
);

   localparam int SW = vgfc_pkg::SIZE_W;

   // mirror of the voxel words: bit 0 on, bits 1..6 covered flags
   vgfc_pkg::word_type   grid_word [0:4095];
   logic [SW-1:0]        extent_x_reg;
   logic [SW-1:0]        extent_y_reg;
   logic [SW-1:0]        extent_z_reg;
   vgfc_pkg::result_type predicted_reports [$];
   int                   mismatch_count = 0;
   int                   pending_reg    = 0;

   assign fail_total    = mismatch_count;
   assign pending_total = pending_reg;

   // zero acts as one, anything past the grid acts as the full edge
   function automatic logic [SW-1:0] usable_extent(input logic [SW-1:0] v);
      if (v == '0) return SW'(1);
      if (v > MAX_EDGE) return SW'(MAX_EDGE);
      return v;
   endfunction

   // apply one request to the mirror and build the report it should produce
   function automatic vgfc_pkg::result_type predict_voxel_op(
         input vgfc_pkg::op_type op,
         input logic [vgfc_pkg::POS_W-1:0] px,
         input logic [vgfc_pkg::POS_W-1:0] py,
         input logic [vgfc_pkg::POS_W-1:0] pz);
      vgfc_pkg::result_type        res;
      logic [SW-1:0]               ext [3];
      logic [SW-1:0]               pos [3];
      logic [SW-1:0]               nb  [3];
      logic [11:0]                 home;
      logic                        want_on;
      logic                        changed;
      logic [vgfc_pkg::FACE_N-1:0] covered;
      logic [2:0]                  total;
      int                          axis;
      res    = '0;
      ext[0] = usable_extent(extent_x_reg);
      ext[1] = usable_extent(extent_y_reg);
      ext[2] = usable_extent(extent_z_reg);
      pos[0] = {1'b0, px};
      pos[1] = {1'b0, py};
      pos[2] = {1'b0, pz};
      if (pos[0] >= ext[0] || pos[1] >= ext[1] || pos[2] >= ext[2]) begin
         res.out_of_range = 1'b1;
         return res;
      end
      home    = {px, py, pz};
      changed = 1'b0;
      if (op == vgfc_pkg::OP_SET || op == vgfc_pkg::OP_CLR) begin
         want_on = (op == vgfc_pkg::OP_SET);
         if (grid_word[home][0] != want_on) begin
            changed            = 1'b1;
            grid_word[home][0] = want_on;
            // touch the facing flag of every in-bounds axis neighbor
            for (vgfc_pkg::face_type f = vgfc_pkg::FACE_NEG_X; f != vgfc_pkg::FACE_END;
                 f++) begin
               axis = int'(f >> 1);
               nb   = pos;
               if (f[0] == 1'b0) begin
                  if (pos[axis] == 0) continue;
                  nb[axis] = pos[axis] - SW'(1);
               end else begin
                  if (pos[axis] + 1 >= ext[axis]) continue;
                  nb[axis] = pos[axis] + SW'(1);
               end
               grid_word[{nb[0][3:0], nb[1][3:0], nb[2][3:0]}][1 + int'(f ^ 3'd1)] = want_on;
            end
         end
      end
      covered = grid_word[home][vgfc_pkg::WORD_W-1:1];
      total   = '0;
      for (int i = 0; i < vgfc_pkg::FACE_N; i++) begin
         total = total + {2'b00, covered[i]};
      end
      res.occupied       = grid_word[home][0];
      res.was_changed    = changed;
      res.exposed_faces  = ~covered;
      res.neighbor_total = total;
      res.visible        = res.occupied && (total < vgfc_pkg::FULL_ENCLOSURE);
      return res;
   endfunction

   task automatic check_field(input string label, input logic [5:0] want,
                              input logic [5:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // scoreboard: responses first so an early response is never masked
   always @(posedge clock) begin
      vgfc_pkg::result_type want;
      if (reset) begin
         foreach (grid_word[i]) grid_word[i] = '0;
         extent_x_reg = vgfc_pkg::SIZE_RESET;
         extent_y_reg = vgfc_pkg::SIZE_RESET;
         extent_z_reg = vgfc_pkg::SIZE_RESET;
         predicted_reports.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_reports.size() == 0) begin
               $display("%0t: response with none expected, expected none actual occ=%0b",
                        $time, rsp_mon.occupied);
               mismatch_count++;
            end else begin
               want = predicted_reports.pop_front();
               check_field("occupied", want.occupied, rsp_mon.occupied);
               check_field("was_changed", want.was_changed, rsp_mon.was_changed);
               check_field("exposed_faces", want.exposed_faces, rsp_mon.exposed_faces);
               check_field("neighbor_total", want.neighbor_total, rsp_mon.neighbor_total);
               check_field("visible", want.visible, rsp_mon.visible);
               check_field("out_of_range", want.out_of_range, rsp_mon.out_of_range);
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               vgfc_pkg::CSR_SIZE_X: extent_x_reg = csr_mon.data;
               vgfc_pkg::CSR_SIZE_Y: extent_y_reg = csr_mon.data;
               vgfc_pkg::CSR_SIZE_Z: extent_z_reg = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            predicted_reports = {predicted_reports,
                                 predict_voxel_op(req_mon.op, req_mon.pos_x,
                                                  req_mon.pos_y, req_mon.pos_z)};
         end
      end
      pending_reg <= predicted_reports.size();
   end

endmodule

FILE: bench/voxel_grid_face_culler_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_grid_face_culler_top_test - bench top of the voxel face culler
// Drives voxel requests and extent writes, throttles the response side and
// leaves prediction and comparison to the checker. Directed corner cases
// first, then random phases over a range of grid extents.
// ----------------------------------------------------------------------------
module voxel_grid_face_culler_top_test;

   localparam int                      CYCLE_LIMIT = 400000;
   localparam int                      LONG_HOLD   = 300;
   localparam vgfc_pkg::op_type        OP_READ     = 2'd2;
   localparam vgfc_pkg::op_type        OP_ODD      = 2'd3;   // undefined code, reads
   localparam vgfc_pkg::csr_index_type CSR_SPARE   = 2'd3;   // no register behind it

   logic clock = 1'b0;
   logic reset;
   int   fail_total;
   int   pending_total;
   int   cycle_count;
   int   hold_request = 0;
   bit   send_steady  = 1'b0;
   bit   take_steady  = 1'b0;
   int   span_x = 16;
   int   span_y = 16;
   int   span_z = 16;

   vgfc_req_if req_chan ();
   vgfc_rsp_if rsp_chan ();
   vgfc_csr_if csr_chan ();

   voxel_grid_face_culler_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   voxel_grid_face_culler_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_mon       (csr_chan),
      .fail_total    (fail_total),
      .pending_total (pending_total)
   );

   always #5 clock = ~clock;

   function automatic int usable(input int v);
      if (v < 1) return 1;
      if (v > 16) return 16;
      return v;
   endfunction

   function automatic vgfc_pkg::op_type pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return vgfc_pkg::OP_SET;
      if (r < 70) return vgfc_pkg::OP_CLR;
      if (r < 96) return OP_READ;
      return OP_ODD;
   endfunction

   // mostly inside a 4-wide window so neighbors actually meet
   function automatic logic [3:0] pick_coord(input int base);
      if ($urandom_range(0, 99) < 15) return 4'($urandom_range(0, 15));
      return 4'(base + $urandom_range(0, 3));
   endfunction

   // one request; valid stays high when the next one follows at once
   task automatic send_request(input vgfc_pkg::op_type op, input logic [3:0] x,
                               input logic [3:0] y, input logic [3:0] z);
      int gap;
      if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
      gap = send_steady ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.pos_x <= x;
      req_chan.pos_y <= y;
      req_chan.pos_z <= z;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // stop offering and wait until every predicted report has come back
   task automatic drain_requests();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_total != 0) @(posedge clock);
   endtask

   task automatic write_register(input vgfc_pkg::csr_index_type idx, input int value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= 5'(value);
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // extents change only with the block idle
   task automatic set_extents(input int sx, input int sy, input int sz,
                              input bit with_spare);
      drain_requests();
      if (with_spare) write_register(CSR_SPARE, 31);
      write_register(vgfc_pkg::CSR_SIZE_X, sx);
      write_register(vgfc_pkg::CSR_SIZE_Y, sy);
      write_register(vgfc_pkg::CSR_SIZE_Z, sz);
      csr_chan.valid <= 1'b0;
      span_x = usable(sx);
      span_y = usable(sy);
      span_z = usable(sz);
   endtask

   task automatic run_phase(input int count, input bit with_hold);
      int base_x;
      int base_y;
      int base_z;
      base_x = (span_x > 4) ? $urandom_range(0, span_x - 4) : 0;
      base_y = (span_y > 4) ? $urandom_range(0, span_y - 4) : 0;
      base_z = (span_z > 4) ? $urandom_range(0, span_z - 4) : 0;
      for (int n = 0; n < count; n++) begin
         if (with_hold && n == 20) hold_request = LONG_HOLD;
         send_request(pick_op(), pick_coord(base_x), pick_coord(base_y),
                      pick_coord(base_z));
      end
   endtask

   // response side: random stalls, steady stretches, one long hold-off
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      forever begin
         if ($urandom_range(0, 29) == 0) take_steady = !take_steady;
         if (hold_request > 0) begin
            stall        = hold_request;
            hold_request = 0;
         end else begin
            stall = take_steady ? 0 : $urandom_range(0, 18);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("voxel_grid_face_culler_top verification failed");
      $finish;
   end

   // stimulus and verdict
   initial begin
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.op    <= OP_READ;
      req_chan.pos_x <= '0;
      req_chan.pos_y <= '0;
      req_chan.pos_z <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= vgfc_pkg::CSR_SIZE_X;
      csr_chan.data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // full grid: cleared read, border faces, no-op set, buried voxel
      send_request(OP_READ, 4'd0, 4'd0, 4'd0);
      send_request(vgfc_pkg::OP_SET, 4'd0, 4'd0, 4'd0);
      send_request(vgfc_pkg::OP_SET, 4'd0, 4'd0, 4'd0);
      send_request(vgfc_pkg::OP_SET, 4'd1, 4'd0, 4'd0);
      send_request(OP_READ, 4'd0, 4'd0, 4'd0);
      send_request(vgfc_pkg::OP_SET, 4'd5, 4'd5, 4'd5);
      send_request(vgfc_pkg::OP_SET, 4'd4, 4'd5, 4'd5);
      send_request(vgfc_pkg::OP_SET, 4'd6, 4'd5, 4'd5);
      send_request(vgfc_pkg::OP_SET, 4'd5, 4'd4, 4'd5);
      send_request(vgfc_pkg::OP_SET, 4'd5, 4'd6, 4'd5);
      send_request(vgfc_pkg::OP_SET, 4'd5, 4'd5, 4'd4);
      send_request(vgfc_pkg::OP_SET, 4'd5, 4'd5, 4'd6);
      send_request(OP_READ, 4'd5, 4'd5, 4'd5);
      // off voxel keeps its flags; undefined code reads
      send_request(vgfc_pkg::OP_CLR, 4'd5, 4'd5, 4'd5);
      send_request(OP_ODD, 4'd5, 4'd5, 4'd5);
      send_request(vgfc_pkg::OP_CLR, 4'd5, 4'd5, 4'd5);
      send_request(vgfc_pkg::OP_SET, 4'd15, 4'd15, 4'd15);
      send_request(OP_READ, 4'd15, 4'd15, 4'd15);
      send_request(vgfc_pkg::OP_SET, 4'd14, 4'd15, 4'd15);
      send_request(OP_READ, 4'd15, 4'd15, 4'd15);

      // odd extents: zero on x, oversize on y; stale flags stay behind
      set_extents(0, 31, 16, 1'b1);
      send_request(OP_READ, 4'd1, 4'd0, 4'd0);
      send_request(vgfc_pkg::OP_SET, 4'd0, 4'd15, 4'd3);
      send_request(vgfc_pkg::OP_CLR, 4'd0, 4'd0, 4'd0);
      send_request(OP_ODD, 4'd15, 4'd15, 4'd15);
      send_request(vgfc_pkg::OP_SET, 4'd0, 4'd14, 4'd3);

      // random phases over several extents
      for (int p = 0; p < 9; p++) begin
         case (p)
            0: set_extents(16, 16, 16, 1'b0);
            1: set_extents(1, 1, 1, 1'b0);
            2: set_extents(2, 2, 2, 1'b0);
            3: set_extents(16, 1, 16, 1'b0);
            4: set_extents(3, 5, 2, 1'b0);
            5: set_extents(0, 31, 7, 1'b0);
            8: set_extents(16, 16, 16, 1'b0);
            default: set_extents($urandom_range(1, 16), $urandom_range(0, 31),
                                 $urandom_range(1, 16), 1'b0);
         endcase
         run_phase(75, p == 3);
      end

      drain_requests();
      repeat (20) @(posedge clock);
      if (fail_total == 0) begin
         $display("voxel_grid_face_culler_top verification clean");
      end else begin
         $display("voxel_grid_face_culler_top verification failed");
      end
      $finish;
   end

endmodule

FILE: voxel_grid_face_culler_top.f
rtl/vgfc_pkg.sv
rtl/vgfc_if.sv
rtl/vgfc_voxel_ram.sv
rtl/voxel_grid_face_culler_top.sv
rtl/vgfc_checker.sv
bench/voxel_grid_face_culler_checker.sv
bench/voxel_grid_face_culler_top_test.sv
